>>> src/random_budget_elimination_top_defines.svh
// Assertion macros for the random budget elimination block.
// Used by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef RANDOM_BUDGET_ELIMINATION_TOP_DEFINES_SVH
`define RANDOM_BUDGET_ELIMINATION_TOP_DEFINES_SVH

`define RBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define RBE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/rbe_pkg.sv
// Shared types and constants for random budget elimination.
// No dependencies.
package rbe_pkg;
  localparam int ACC_W = 40;
  localparam int CNT_W = 7;
  localparam int IDX_W = 6;
  localparam int MASK_W = 64;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_DRAW  = 2'd2;

  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_TOTAL  = 1'b1;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_START,
    CMD_DRAW
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       cost;
    logic              lock_in;
    logic              lock_out;
    logic [31:0]       frac;
  } qent_t;
endpackage

>>> src/rbe_ifs.sv
// Valid/ready channel interfaces for request and result words.
// Depends on rbe_pkg.
interface rbe_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [rbe_pkg::IDX_W-1:0] action_index;
  logic [31:0]               action_cost;
  logic                      lock_in;
  logic                      lock_out;
  logic [31:0]               random_fraction;
  modport source(output valid, req_type, action_index, action_cost, lock_in, lock_out,
                 random_fraction, input ready);
  modport sink(input valid, req_type, action_index, action_cost, lock_in, lock_out,
               random_fraction, output ready);
endinterface

interface rbe_out_if;
  logic                       valid;
  logic                       ready;
  logic                       removed_valid;
  logic [rbe_pkg::IDX_W-1:0]  removed_index;
  logic [rbe_pkg::ACC_W-1:0]  current_cost;
  logic [rbe_pkg::MASK_W-1:0] funded_mask;
  logic [rbe_pkg::CNT_W-1:0]  removable_left;
  logic                       solution_done;
  modport source(output valid, removed_valid, removed_index, current_cost, funded_mask,
                 removable_left, solution_done, input ready);
  modport sink(input valid, removed_valid, removed_index, current_cost, funded_mask,
               removable_left, solution_done, output ready);
endinterface

>>> src/rbe_front.sv
// Front end: accepts request words, decodes them into commands, two-entry queue.
// Depends on rbe_pkg and rbe_ifs.
module rbe_front #(
  parameter int MAX_ACTIONS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  rbe_in_if.sink         in_ch,
  output rbe_pkg::qent_t q_ent,
  output logic           q_valid,
  input  logic           q_pop
);
  import rbe_pkg::*;

  qent_t       fifo_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  qent_t       dec;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_ent = fifo_r[rp_r];

  always_comb begin
    dec.idx = in_ch.action_index;
    dec.cost = in_ch.action_cost;
    dec.lock_in = in_ch.lock_in;
    dec.lock_out = in_ch.lock_out;
    dec.frac = in_ch.random_fraction;
    unique case (in_ch.req_type)
      REQ_LOAD: begin
        if (32'(in_ch.action_index) < MAX_ACTIONS) dec.cmd = CMD_LOAD;
        else dec.cmd = CMD_NOP;
      end
      REQ_START: dec.cmd = CMD_START;
      REQ_DRAW:  dec.cmd = CMD_DRAW;
      default:   dec.cmd = CMD_NOP;
    endcase
  end

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = ~wp_r;
      cnt_nxt = cnt_nxt + 2'd1;
    end
    if (q_pop && q_valid) begin
      rp_nxt = ~rp_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= dec;
  end
endmodule

>>> src/rbe_back.sv
// Back end: sequencer with cost memory, start scan, rank select, result register.
// Depends on rbe_pkg, rbe_ifs and the assertion macro header.
`include "random_budget_elimination_top_defines.svh"
module rbe_back #(
  parameter int MAX_ACTIONS = 64,
  parameter int COST_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rbe_pkg::qent_t            q_ent,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [rbe_pkg::ACC_W-1:0] cfg_wdata,
  rbe_out_if.source                 out_ch
);
  import rbe_pkg::*;

  localparam int AW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
  localparam int SW = (COST_BITS < 32) ? COST_BITS : 32;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_ACTIONS - 1);
  localparam logic [CNT_W-1:0] MAXN = CNT_W'(MAX_ACTIONS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SACC = 3'd2;
  localparam logic [2:0] S_DSEL = 3'd3;
  localparam logic [2:0] S_DRD  = 3'd4;
  localparam logic [2:0] S_DSUB = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [SW-1:0]     cost_mem [MAX_ACTIONS];
  logic [SW-1:0]     rd_data_r;
  logic [AW-1:0]     rd_addr;

  logic [2:0]        st_r, st_nxt;
  logic [ACC_W-1:0]  budget_r, total_pad;
  logic [CNT_W-1:0]  total_r;
  logic [MASK_W-1:0] li_r, lo_r, rem_r, fund_r, srem_r;
  logic [ACC_W-1:0]  run_r, sum_r;
  logic [CNT_W-1:0]  cnt_r, scnt_r, scan_r, k_r, neff;
  logic [IDX_W-1:0]  a_r;
  logic              removed_r;
  logic [38:0]       prod;
  logic [ACC_W:0]    sum_add;
  logic [ACC_W-1:0]  cext;
  logic [MASK_W-1:0] act;
  logic              draw_ok;

  assign total_pad = '0;
  assign neff = (total_r > MAXN) ? MAXN : total_r;
  assign prod = 39'(q_ent.frac) * 39'(cnt_r);
  assign draw_ok = (run_r > budget_r) && (cnt_r != '0);
  assign cext = ACC_W'(rd_data_r);
  assign sum_add = {1'b0, sum_r} + {1'b0, cext};
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign rd_addr = (st_r == S_DRD) ? a_r[AW-1:0] : scan_r[AW-1:0];

  always_comb begin
    for (int i = 0; i < MASK_W; i++) act[i] = (CNT_W'(i) < neff) && (i < MAX_ACTIONS);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_ent.cmd)
            CMD_START: st_nxt = S_SRD;
            CMD_DRAW:  st_nxt = draw_ok ? S_DSEL : S_FIN;
            default:   st_nxt = S_FIN;
          endcase
        end
      end
      S_SRD:  st_nxt = S_SACC;
      S_SACC: st_nxt = (scan_r == LAST) ? S_FIN : S_SRD;
      S_DSEL: st_nxt = (rem_r[scan_r[IDX_W-1:0]] && k_r == '0) ? S_DRD : S_DSEL;
      S_DRD:  st_nxt = S_DSUB;
      S_DSUB: st_nxt = S_FIN;
      S_FIN:  st_nxt = (!out_ch.valid || out_ch.ready) ? S_IDLE : S_FIN;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      budget_r <= '0;
      total_r <= MAXN | CNT_W'(total_pad);
      li_r <= '0;
      lo_r <= '0;
      rem_r <= '0;
      fund_r <= '1;
      run_r <= '0;
      cnt_r <= '0;
      removed_r <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_BUDGET) budget_r <= cfg_wdata;
        else total_r <= cfg_wdata[CNT_W-1:0];
      end
      if (st_r == S_FIN && (!out_ch.valid || out_ch.ready)) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          removed_r <= 1'b0;
          scan_r <= '0;
          sum_r <= '0;
          scnt_r <= '0;
          srem_r <= '0;
          k_r <= prod[38:32];
          if (q_valid && q_ent.cmd == CMD_LOAD) begin
            li_r[q_ent.idx] <= q_ent.lock_in;
            lo_r[q_ent.idx] <= q_ent.lock_out;
          end
        end
        S_SACC: begin
          if (act[scan_r[IDX_W-1:0]] && !lo_r[scan_r[IDX_W-1:0]]) begin
            sum_r <= sum_add[ACC_W] ? ACC_MAX : sum_add[ACC_W-1:0];
            if (!li_r[scan_r[IDX_W-1:0]] && rd_data_r != '0) begin
              srem_r[scan_r[IDX_W-1:0]] <= 1'b1;
              scnt_r <= scnt_r + CNT_W'(1);
            end
          end
          scan_r <= scan_r + CNT_W'(1);
          if (scan_r == LAST) begin
            fund_r <= act & ~lo_r;
            run_r <= (act[scan_r[IDX_W-1:0]] && !lo_r[scan_r[IDX_W-1:0]])
                     ? (sum_add[ACC_W] ? ACC_MAX : sum_add[ACC_W-1:0]) : sum_r;
            rem_r <= srem_r | ((act[scan_r[IDX_W-1:0]] && !lo_r[scan_r[IDX_W-1:0]] &&
                     !li_r[scan_r[IDX_W-1:0]] && rd_data_r != '0)
                     ? (MASK_W'(1) << scan_r[IDX_W-1:0]) : '0);
            cnt_r <= scnt_r + ((act[scan_r[IDX_W-1:0]] && !lo_r[scan_r[IDX_W-1:0]] &&
                     !li_r[scan_r[IDX_W-1:0]] && rd_data_r != '0) ? CNT_W'(1) : '0);
          end
        end
        S_DSEL: begin
          if (rem_r[scan_r[IDX_W-1:0]]) begin
            if (k_r == '0) a_r <= scan_r[IDX_W-1:0];
            else k_r <= k_r - CNT_W'(1);
          end
          scan_r <= scan_r + CNT_W'(1);
        end
        S_DSUB: begin
          run_r <= (run_r > cext) ? run_r - cext : '0;
          rem_r[a_r] <= 1'b0;
          fund_r[a_r] <= 1'b0;
          cnt_r <= cnt_r - CNT_W'(1);
          removed_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_FIN && (!out_ch.valid || out_ch.ready)) begin
      out_ch.removed_valid <= removed_r;
      out_ch.removed_index <= removed_r ? a_r : '0;
      out_ch.current_cost <= run_r;
      out_ch.funded_mask <= fund_r;
      out_ch.removable_left <= cnt_r;
      out_ch.solution_done <= (run_r <= budget_r) || (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid && q_ent.cmd == CMD_LOAD)
      cost_mem[q_ent.idx[AW-1:0]] <= SW'(q_ent.cost);
    rd_data_r <= cost_mem[rd_addr];
  end

  `RBE_ASSERT(a_cnt_match, (st_r != S_IDLE) || (cnt_r == CNT_W'($countones(rem_r))), "cnt")
  `RBE_ASSERT_IMP(a_rem_funded, st_r == S_DSUB, fund_r[a_r] && rem_r[a_r], "removing unfunded action")
  `RBE_ASSERT_IMP(a_sel_bound, st_r == S_DSEL, scan_r < MAXN, "rank select overran mask")
  `RBE_ASSERT_IMP(a_no_pop_busy, st_r != S_IDLE, !q_pop, "pop while busy")
endmodule

>>> src/random_budget_elimination_top.sv
// Random budget elimination: load/nop update state and report; start scans all cost entries;
// draw: report if nothing to remove, else serial rank select, then cost read and subtract.
// One request in work at a time; a two-word queue keeps accepting meanwhile.
// A result still waiting on out_ch.ready holds the back end in S_FIN until it is taken.
// Synchronous active-low reset clears control state, lock/removable masks and running cost.
// Depends on rbe_pkg, rbe_ifs, rbe_front, rbe_back.
module random_budget_elimination_top #(
  parameter int MAX_ACTIONS = 64,
  parameter int COST_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rbe_in_if.sink                    in_ch,
  rbe_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [rbe_pkg::ACC_W-1:0] cfg_wdata
);
  import rbe_pkg::*;

  qent_t q_ent;
  logic  q_valid, q_pop;

  rbe_front #(.MAX_ACTIONS(MAX_ACTIONS)) u_front (
    .clk, .rst_n, .in_ch, .q_ent, .q_valid, .q_pop
  );

  rbe_back #(.MAX_ACTIONS(MAX_ACTIONS), .COST_BITS(COST_BITS)) u_back (
    .clk, .rst_n, .q_ent, .q_valid, .q_pop, .cfg_we, .cfg_index, .cfg_wdata, .out_ch
  );
endmodule

>>> bench/tb_rbe_ifs.sv
// Testbench-side note: channel interfaces come from the RTL file rbe_ifs.sv.
// This file holds the shared bench constants; no dependencies.
`timescale 1ns / 1ps
package tb_rbe_pkg;
  localparam int SEND_IDLE_A = 9;
  localparam int RECV_IDLE_A = 88;
  localparam int LONG_HOLD   = 400;
endpackage

>>> bench/tb_random_budget_elimination_top.sv
// Bench for random_budget_elimination_top: directed table, then random traffic.
// Results checked against an in-bench budget elimination predictor.
// Depends on rbe_pkg, rbe_ifs, tb_rbe_pkg and the block RTL.
`timescale 1ns / 1ps
module tb_random_budget_elimination_top;
  import rbe_pkg::*;
  import tb_rbe_pkg::*;

  typedef struct packed {
    logic [1:0]  req;
    logic [5:0]  idx;
    logic [31:0] cost;
    logic        lin;
    logic        lout;
    logic [31:0] frac;
  } req_word_t;

  typedef struct packed {
    logic        rv;
    logic [5:0]  ridx;
    logic [39:0] cost;
    logic [63:0] funded;
    logic [6:0]  left;
    logic        done;
  } res_word_t;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0, cfg_index = 0;
  logic [39:0] cfg_wdata = 0;
  rbe_in_if in_ch();
  rbe_out_if out_ch();

  random_budget_elimination_top i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .out_ch(out_ch), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata));

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // predictor state
  logic [31:0] m_cost [64];
  logic [63:0] m_lin, m_lout, m_rem, m_funded;
  logic [39:0] m_run, m_budget;
  logic [6:0]  m_cnt, m_total;
  res_word_t   exp_q[$];
  res_word_t   tbl_res[$];
  logic        tbl_chk[$];
  int errors = 0, cycles = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold = 0;

  function automatic res_word_t predict_elimination(req_word_t w);
    res_word_t r;
    logic [63:0] act, bit1;
    logic [40:0] sum;
    logic [63:0] k;
    int a;
    r = '0;
    if (w.req == REQ_LOAD) begin
      m_cost[w.idx] = w.cost;
      m_lin[w.idx] = w.lin;
      m_lout[w.idx] = w.lout;
    end else if (w.req == REQ_START) begin
      act = (m_total >= 64) ? '1 : ((64'd1 << m_total) - 1);
      sum = 0; m_rem = 0; m_cnt = 0;
      for (int i = 0; i < 64; i++) begin
        if (act[i] && !m_lout[i]) begin
          sum = sum + m_cost[i];
          if (sum > ACC_MAX) sum = ACC_MAX;
          if (!m_lin[i] && m_cost[i] != 0) begin
            m_rem[i] = 1; m_cnt++;
          end
        end
      end
      m_funded = act & ~m_lout;
      m_run = sum[39:0];
    end else if (w.req == REQ_DRAW) begin
      if (m_run > m_budget && m_cnt > 0) begin
        k = (64'(w.frac) * m_cnt) >> 32;
        a = 0;
        for (int i = 0; i < 64; i++)
          if (m_rem[i]) begin
            if (k == 0) begin a = i; break; end
            k--;
          end
        m_run = (m_run > m_cost[a]) ? m_run - m_cost[a] : 0;
        bit1 = 64'd1 << a;
        m_rem &= ~bit1;
        m_funded &= ~bit1;
        m_cnt--;
        r.rv = 1; r.ridx = 6'(a);
      end
    end
    r.cost = m_run; r.funded = m_funded; r.left = m_cnt;
    r.done = (m_run <= m_budget) || (m_cnt == 0);
    return r;
  endfunction

  req_word_t send_q[$];

  task automatic write_reg(logic idx, logic [39:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_BUDGET) m_budget = v; else m_total = (v[6:0] > 7'd64) ? 7'd64 : v[6:0];
  endtask

  task automatic drain;
    in_ch.valid <= 0;
    while (exp_q.size() > 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  task automatic send(req_word_t w);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    {in_ch.req_type, in_ch.action_index, in_ch.action_cost, in_ch.lock_in,
     in_ch.lock_out, in_ch.random_fraction} <= w;
    do @(posedge clk); while (!in_ch.ready);
    exp_q.push_back(predict_elimination(w));
  endtask

  function automatic req_word_t mk(logic [1:0] rq, logic [5:0] i, logic [31:0] c,
                                   logic li, logic lo, logic [31:0] f);
    return {rq, i, c, li, lo, f};
  endfunction

  task automatic rand_phase(int n);
    req_word_t w;
    int p;
    for (int j = 0; j < n; j++) begin
      p = $urandom_range(99);
      if (p < 45) begin
        w = mk(REQ_LOAD, 6'($urandom), $urandom_range(3) == 0 ? $urandom_range(3) : $urandom,
               $urandom_range(4) == 0, $urandom_range(6) == 0, $urandom);
      end else if (p < 52) w = mk(REQ_START, 6'($urandom), $urandom, 1'($urandom),
                                  1'($urandom), $urandom);
      else if (p < 97) w = mk(REQ_DRAW, 6'($urandom), $urandom, 1'($urandom),
                              1'($urandom), $urandom);
      else w = mk(2'd3, 6'($urandom), $urandom, 1'($urandom), 1'($urandom), $urandom);
      send(w);
    end
  endtask

  // receiver
  always @(posedge clk) begin
    if (hold) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res_word_t got, e;
      got = {out_ch.removed_valid, out_ch.removed_index, out_ch.current_cost,
             out_ch.funded_mask, out_ch.removable_left, out_ch.solution_done};
      if (exp_q.size() == 0) begin
        errors++;
        $display("%0t unexpected word %h", $time, got);
      end else begin
        e = exp_q.pop_front();
        if (tbl_chk.size() > 0) begin
          if (tbl_chk.pop_front() && tbl_res[0] != e) begin
            errors++;
            $display("%0t table exp %h model %h", $time, tbl_res[0], e);
          end
          void'(tbl_res.pop_front());
        end
        if (got.rv != e.rv || got.ridx != e.ridx || got.cost != e.cost ||
            got.funded != e.funded || got.left != e.left || got.done != e.done) begin
          errors++;
          $display("%0t mismatch exp %h got %h", $time, e, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    req_word_t w;
    req_word_t tbl_w[$];
    res_word_t tbl_r[$];
    bit tbl_c[$];
    in_ch.valid = 0; out_ch.ready = 0;
    {in_ch.req_type, in_ch.action_index, in_ch.action_cost, in_ch.lock_in,
     in_ch.lock_out, in_ch.random_fraction} = '0;
    for (int i = 0; i < 64; i++) m_cost[i] = 0;
    m_lin = 0; m_lout = 0; m_rem = 0; m_funded = '1; m_run = 0; m_cnt = 0;
    m_budget = 0; m_total = 64;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // directed: nop and draw after reset, then loads of all 64 actions, a start and draws
    tbl_w.push_back(mk(2'd3, 0, 0, 0, 0, 0));
    tbl_r.push_back({1'b0, 6'd0, 40'd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 1'b1}); tbl_c.push_back(1);
    tbl_w.push_back(mk(REQ_DRAW, 0, 0, 0, 0, '1));
    tbl_r.push_back({1'b0, 6'd0, 40'd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 1'b1}); tbl_c.push_back(1);
    for (int i = 0; i < 64; i++) begin
      w = mk(REQ_LOAD, 6'(i), (i % 5 == 0) ? 32'hFFFF_FFFF : 32'(i), i == 3,
             i == 4 || i == 3, 0);
      tbl_w.push_back(w); tbl_r.push_back('0); tbl_c.push_back(0);
    end
    tbl_w.push_back(mk(REQ_START, 0, 0, 0, 0, 0)); tbl_r.push_back('0); tbl_c.push_back(0);
    tbl_w.push_back(mk(REQ_DRAW, 0, 0, 0, 0, 0)); tbl_r.push_back('0); tbl_c.push_back(0);
    tbl_w.push_back(mk(REQ_DRAW, 0, 0, 0, 0, '1)); tbl_r.push_back('0); tbl_c.push_back(0);
    tbl_w.push_back(mk(REQ_DRAW, 0, 0, 0, 0, 32'h8000_0000)); tbl_r.push_back('0);
    tbl_c.push_back(0);
    foreach (tbl_w[i]) begin
      tbl_res.push_back(tbl_r[i]); tbl_chk.push_back(tbl_c[i]);
      send(tbl_w[i]);
    end
    drain();
    write_reg(CFG_TOTAL, 1);
    write_reg(CFG_BUDGET, 0);
    send(mk(REQ_START, 0, 0, 0, 0, 0));
    send(mk(REQ_DRAW, 0, 0, 0, 0, '1));
    drain();
    write_reg(CFG_TOTAL, 64);
    write_reg(CFG_BUDGET, 40'd1000);
    send_idle = SEND_IDLE_A; recv_idle = RECV_IDLE_A;
    rand_phase(230);
    drain();
    write_reg(CFG_BUDGET, ACC_MAX);
    write_reg(CFG_TOTAL, 40'($urandom_range(2, 63)));
    send_idle = RECV_IDLE_A; recv_idle = SEND_IDLE_A;
    rand_phase(60);
    drain();
    write_reg(CFG_BUDGET, 40'($urandom_range(0, 100000)));
    write_reg(CFG_TOTAL, 64);
    send_idle = 0; recv_idle = 0;
    fork
      begin hold = 1; repeat (LONG_HOLD) @(posedge clk); hold = 0; end
      rand_phase(30);
    join
    rand_phase(330);
    drain();
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+src
src/rbe_pkg.sv
src/rbe_ifs.sv
src/rbe_front.sv
src/rbe_back.sv
src/random_budget_elimination_top.sv
bench/tb_rbe_ifs.sv
bench/tb_random_budget_elimination_top.sv
